// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, request and status codes and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEPTH       = 32;
    localparam int KEY_WIDTH   = 32;
    localparam int KEY_FIELD_W = 31;

    // Stored keys are the request key cut to the smaller of KEY_WIDTH and KEY_FIELD_W bits.
    localparam int STORE_W = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam logic [1:0] REQ_DELETE = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;
    localparam logic [1:0] STAT_EMPTY   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EV,
        S_DEL_RD,
        S_DEL_EV,
        S_SH_RD,
        S_SH_EV,
        S_DMP_RD,
        S_DMP_EV,
        S_RESULT
    } state_t;

endpackage

// ----- rtl/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// Sorted key table
// Ordered store of up to DEPTH keys with insert, delete and dump requests.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with req_type and key; results leave on
// out_valid/out_stall with key_out, status and last. A request is taken when
// valid is high and stall is low at a rising edge of clk.
// The block works on one request at a time and holds in_stall high until its
// last result has been loaded into the output register.
// One sequencer walks the key memory through a single port, in two steps per
// entry (read, then compare or move):
//   insert: walks down from the top past every entry at or above the new key,
//   delete: searches from the bottom, then closes the gap,
//   dump:   reads every stored key, one result each, last on the final key.
// Insert and delete give one status result; a full table drops the insert,
// a key that is not found or an empty table leaves the contents unchanged.
// While the receiver stalls, the output register holds its result and the
// sequencer waits before loading the next one.
// rst_n clears the count and all handshake state; the key memory itself is
// not cleared, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      req_type,
    input  logic [skt_pkg::KEY_FIELD_W-1:0] key,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [skt_pkg::KEY_FIELD_W-1:0] key_out,
    output logic [1:0]                      status,
    output logic                            last
);

    localparam int STORE_W = skt_pkg::STORE_W;
    localparam int IDX_W   = skt_pkg::IDX_W;
    localparam int CNT_W   = skt_pkg::CNT_W;
    localparam int KF_W    = skt_pkg::KEY_FIELD_W;

    logic [STORE_W-1:0] mem [skt_pkg::DEPTH];

    skt_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [STORE_W-1:0] key_reg, key_next;
    logic [1:0]         res_reg, res_next;
    logic [STORE_W-1:0] rd_data_reg;

    logic               out_valid_reg, out_valid_next;
    logic [KF_W-1:0]    key_out_reg, key_out_next;
    logic [1:0]         status_reg, status_next;
    logic               last_reg, last_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [STORE_W-1:0] wr_data;
    logic               in_fire;
    logic               out_free;
    logic               out_load;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   idx_dec;

    assign in_stall = (state_reg != skt_pkg::S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        res_reg     <= res_next;
        key_out_reg <= key_out_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    // Single-port key memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        key_out_next   = key_out_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        out_load       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = key_reg;

        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next = key[STORE_W-1:0];
                    idx_next = '0;
                    case (req_type)
                        skt_pkg::REQ_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = skt_pkg::STAT_EMPTY;
                                state_next = skt_pkg::S_RESULT;
                            end
                            else
                            begin
                                state_next = skt_pkg::S_DEL_RD;
                            end
                        end
                        skt_pkg::REQ_INSERT:
                        begin
                            if (count_reg == CNT_W'(skt_pkg::DEPTH))
                            begin
                                res_next   = skt_pkg::STAT_FULL;
                                state_next = skt_pkg::S_RESULT;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = skt_pkg::S_INS_RD;
                            end
                        end
                        skt_pkg::REQ_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = skt_pkg::STAT_EMPTY;
                                state_next = skt_pkg::S_RESULT;
                            end
                            else
                            begin
                                state_next = skt_pkg::S_DMP_RD;
                            end
                        end
                        default:
                        begin
                            // The unused request code is dropped without a result.
                            state_next = skt_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // Insert walks down from the top, moving each key that is not
            // smaller up by one place, and drops the new key into the gap.
            skt_pkg::S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    res_next   = skt_pkg::STAT_OK;
                    state_next = skt_pkg::S_RESULT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[IDX_W-1:0];
                    state_next = skt_pkg::S_INS_EV;
                end
            end

            skt_pkg::S_INS_EV:
            begin
                wr_en = 1'b1;
                if (rd_data_reg >= key_reg)
                begin
                    wr_data    = rd_data_reg;
                    idx_next   = idx_dec;
                    state_next = skt_pkg::S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    res_next   = skt_pkg::STAT_OK;
                    state_next = skt_pkg::S_RESULT;
                end
            end

            skt_pkg::S_DEL_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_next   = skt_pkg::STAT_MISSING;
                    state_next = skt_pkg::S_RESULT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = skt_pkg::S_DEL_EV;
                end
            end

            skt_pkg::S_DEL_EV:
            begin
                if (rd_data_reg == key_reg)
                begin
                    state_next = skt_pkg::S_SH_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = skt_pkg::S_DEL_RD;
                end
            end

            // Close the gap left by the deleted key, one entry at a time.
            skt_pkg::S_SH_RD:
            begin
                if (idx_inc == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    res_next   = skt_pkg::STAT_OK;
                    state_next = skt_pkg::S_RESULT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[IDX_W-1:0];
                    state_next = skt_pkg::S_SH_EV;
                end
            end

            skt_pkg::S_SH_EV:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data_reg;
                idx_next   = idx_inc;
                state_next = skt_pkg::S_SH_RD;
            end

            skt_pkg::S_DMP_RD:
            begin
                rd_en      = 1'b1;
                state_next = skt_pkg::S_DMP_EV;
            end

            skt_pkg::S_DMP_EV:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    key_out_next = KF_W'(rd_data_reg);
                    status_next  = skt_pkg::STAT_OK;
                    last_next    = (idx_inc == count_reg);
                    if (idx_inc == count_reg)
                    begin
                        state_next = skt_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = skt_pkg::S_DMP_RD;
                    end
                end
            end

            skt_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    key_out_next = '0;
                    status_next  = res_reg;
                    last_next    = 1'b1;
                    state_next   = skt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // The count never goes beyond the table depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(skt_pkg::DEPTH))
        else $error("entry count beyond table depth");

    // A result is only loaded when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

    // The count changes only at the end of an insert or a delete.
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == skt_pkg::S_INS_RD
             || $past(state_reg) == skt_pkg::S_INS_EV
             || $past(state_reg) == skt_pkg::S_SH_RD))
        else $error("entry count changed outside an update");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives insert, delete and dump requests with random idling on both sides
// and checks every result against a behavioural copy of the ordered table.
// ----------------------------------------------------------------------------
class key_table_scoreboard;

    typedef struct packed {
        logic [skt_pkg::KEY_FIELD_W-1:0] key_out;
        logic [1:0]                      status;
        logic                            last;
    } result_t;

    logic [skt_pkg::STORE_W-1:0] keys [skt_pkg::DEPTH];
    int                          fill;
    result_t                     awaited [$];

    int errors;
    int checked;
    int n_insert;
    int n_delete;
    int n_dump;
    int n_unused;
    int n_full;
    int n_missing;
    int n_empty;
    int peak;

    function void expect_status(logic [1:0] st);
        result_t r;
        r.key_out = '0;
        r.status  = st;
        r.last    = 1'b1;
        awaited.push_back(r);
    endfunction

    function logic [skt_pkg::KEY_FIELD_W-1:0] any_stored();
        return skt_pkg::KEY_FIELD_W'(keys[$urandom_range(0, fill - 1)]);
    endfunction

    // Updates the table for one accepted request and queues what it yields.
    function void note_request(logic [1:0] req, logic [skt_pkg::KEY_FIELD_W-1:0] k);
        logic [skt_pkg::STORE_W-1:0] sk;
        int                          pos;
        result_t                     r;
        sk  = k[skt_pkg::STORE_W-1:0];
        pos = 0;
        case (req)
            skt_pkg::REQ_INSERT:
            begin
                n_insert++;
                if (fill >= skt_pkg::DEPTH)
                begin
                    n_full++;
                    expect_status(skt_pkg::STAT_FULL);
                end
                else
                begin
                    // A new key goes in ahead of any keys equal to it.
                    while (pos < fill && keys[pos] < sk)
                        pos++;
                    for (int i = fill; i > pos; i--)
                        keys[i] = keys[i - 1];
                    keys[pos] = sk;
                    fill++;
                    if (fill > peak)
                        peak = fill;
                    expect_status(skt_pkg::STAT_OK);
                end
            end
            skt_pkg::REQ_DELETE:
            begin
                n_delete++;
                if (fill == 0)
                begin
                    n_empty++;
                    expect_status(skt_pkg::STAT_EMPTY);
                end
                else
                begin
                    while (pos < fill && keys[pos] != sk)
                        pos++;
                    if (pos == fill)
                    begin
                        n_missing++;
                        expect_status(skt_pkg::STAT_MISSING);
                    end
                    else
                    begin
                        for (int i = pos; i + 1 < fill; i++)
                            keys[i] = keys[i + 1];
                        fill--;
                        expect_status(skt_pkg::STAT_OK);
                    end
                end
            end
            skt_pkg::REQ_DUMP:
            begin
                n_dump++;
                if (fill == 0)
                    expect_status(skt_pkg::STAT_EMPTY);
                else
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        r.key_out = skt_pkg::KEY_FIELD_W'(keys[i]);
                        r.status  = skt_pkg::STAT_OK;
                        r.last    = (i == fill - 1);
                        awaited.push_back(r);
                    end
                end
            end
            default:
                n_unused++;
        endcase
    endfunction

    function void check_result(logic [skt_pkg::KEY_FIELD_W-1:0] ko, logic [1:0] st,
                               logic l);
        result_t want;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: key_out %h status %0d last %0d", ko, st, l);
        end
        else
        begin
            want = awaited.pop_front();
            checked++;
            if (want.key_out !== ko || want.status !== st || want.last !== l)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch on result %0d: expected key_out %h status %0d",
                              " last %0d, got key_out %h status %0d last %0d"},
                             checked, want.key_out, want.status, want.last, ko, st, l);
            end
        end
    endfunction

endclass

module tb;

    localparam logic [1:0]                      REQ_UNUSED   = 2'd3;
    localparam logic [skt_pkg::KEY_FIELD_W-1:0] KEY_MAX      = '1;
    localparam int                              RANDOM_ITEMS = 405;
    localparam int                              SEGMENT      = 45;
    localparam int                              QUIET_TAIL   = 60;
    localparam int                              DRAIN_CYCLES = 150;
    localparam int                              LIMIT        = 1000000;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [1:0]                      req_type  = skt_pkg::REQ_DELETE;
    logic [skt_pkg::KEY_FIELD_W-1:0] key       = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [skt_pkg::KEY_FIELD_W-1:0] key_out;
    logic [1:0]                      status;
    logic                            last;

    logic idle_on    = 1'b1;
    int   stall_left = 0;
    int   cycles     = 0;

    key_table_scoreboard sb = new;

    sorted_key_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_out   (key_out),
        .status    (status),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycles, sb.awaited.size());
            $display("sorted_key_table verification failed");
            $finish;
        end
    end

    // Receiver stalls come in bursts, started at random while idling is on.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(key_out, status, last);
    end

    task automatic issue_request(input logic [1:0] req,
                                 input logic [skt_pkg::KEY_FIELD_W-1:0] k);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(req, k);
    endtask

    function automatic logic [skt_pkg::KEY_FIELD_W-1:0] random_key();
        case ($urandom_range(0, 3))
            0:       return skt_pkg::KEY_FIELD_W'($urandom_range(0, 15));
            1:       return KEY_MAX - skt_pkg::KEY_FIELD_W'($urandom_range(0, 3));
            default: return skt_pkg::KEY_FIELD_W'($urandom());
        endcase
    endfunction

    initial
    begin
        int                              sent;
        int                              seg;
        int                              pick;
        int                              ins_pct;
        int                              del_pct;
        mix_t                            mode;
        logic [1:0]                      req;
        logic [skt_pkg::KEY_FIELD_W-1:0] k;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then head, tail, middle and duplicate placement.
        issue_request(skt_pkg::REQ_DUMP, KEY_MAX);
        issue_request(skt_pkg::REQ_DELETE, KEY_MAX);
        issue_request(skt_pkg::REQ_INSERT, 31'd500);
        issue_request(skt_pkg::REQ_INSERT, '0);
        issue_request(skt_pkg::REQ_INSERT, KEY_MAX);
        issue_request(skt_pkg::REQ_INSERT, 31'd500);
        issue_request(skt_pkg::REQ_INSERT, 31'd250);
        issue_request(skt_pkg::REQ_INSERT, 31'h2AAA_AAAA);
        issue_request(REQ_UNUSED, 31'h5555_5555);
        issue_request(skt_pkg::REQ_DUMP, '0);
        issue_request(skt_pkg::REQ_DELETE, 31'd999);
        issue_request(skt_pkg::REQ_DELETE, '0);
        issue_request(skt_pkg::REQ_DELETE, KEY_MAX);
        issue_request(skt_pkg::REQ_DELETE, 31'd500);
        issue_request(skt_pkg::REQ_DUMP, 31'h5555_5555);
        issue_request(skt_pkg::REQ_DELETE, 31'd250);
        issue_request(skt_pkg::REQ_DELETE, 31'd500);
        issue_request(skt_pkg::REQ_DELETE, 31'h2AAA_AAAA);
        issue_request(skt_pkg::REQ_DUMP, '0);
        issue_request(skt_pkg::REQ_DELETE, 31'd1);

        // Random part in segments; the first one favours inserts to fill the table.
        sent = 0;
        seg  = -1;
        mode = MODE_FILL;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent / SEGMENT != seg)
            begin
                seg = sent / SEGMENT;
                if (seg != 0)
                    mode = mix_t'($urandom_range(0, 2));
                case (mode)
                    MODE_FILL:
                    begin
                        ins_pct = 80;
                        del_pct = 88;
                    end
                    MODE_DRAIN:
                    begin
                        ins_pct = 20;
                        del_pct = 85;
                    end
                    default:
                    begin
                        ins_pct = 45;
                        del_pct = 87;
                    end
                endcase
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (sent >= RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;

            pick = $urandom_range(0, 99);
            if (pick < ins_pct)
            begin
                req = skt_pkg::REQ_INSERT;
                k   = random_key();
            end
            else if (pick < del_pct)
            begin
                req = skt_pkg::REQ_DELETE;
                if (sb.fill != 0 && $urandom_range(0, 9) < 8)
                    k = sb.any_stored();
                else
                    k = random_key();
            end
            else if (pick < 97)
            begin
                req = skt_pkg::REQ_DUMP;
                k   = skt_pkg::KEY_FIELD_W'($urandom());
            end
            else
            begin
                req = REQ_UNUSED;
                k   = skt_pkg::KEY_FIELD_W'($urandom());
            end
            issue_request(req, k);
            if (req != REQ_UNUSED)
                sent++;
        end
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"requests: %0d inserts (%0d refused when full), %0d deletes",
                  " (%0d not found, %0d on an empty table), %0d dumps, %0d unused codes"},
                 sb.n_insert, sb.n_full, sb.n_delete, sb.n_missing, sb.n_empty,
                 sb.n_dump, sb.n_unused);
        $display("%0d results compared, table peaked at %0d of %0d keys, %0d errors",
                 sb.checked, sb.peak, skt_pkg::DEPTH, sb.errors);
        if (sb.errors == 0)
            $display("sorted_key_table verification clean");
        else
            $display("sorted_key_table verification failed");
        $finish;
    end

endmodule
